>>> rtl/newton_table_interpolator_unit_defines.svh
// Assertion macros for the sequencer of the interpolator.
`ifndef NEWTON_TABLE_INTERPOLATOR_UNIT_DEFINES_SVH
`define NEWTON_TABLE_INTERPOLATOR_UNIT_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define NTI_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("interpolator check failed");

// A trigger that must be followed by a condition in the next cycle.
`define NTI_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("interpolator check failed");

`endif

>>> rtl/nti_pkg.sv
package nti_pkg;

  // Input item: a table point to load or a query abscissa.
  typedef struct packed {
    logic               opcode;
    logic signed [31:0] x_value;
    logic signed [31:0] fx_value;
  } in_item_t;

  // Result item of a query.
  typedef struct packed {
    logic signed [31:0] interp_value;
    logic [1:0]         status;
  } out_item_t;

  localparam logic OPC_LOAD  = 1'b0;
  localparam logic OPC_QUERY = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_FEW   = 2'd1;
  localparam logic [1:0] ST_BAD_ORDER = 2'd2;
  localparam logic [1:0] ST_DIV_ZERO  = 2'd3;

  localparam int MAX_ORDER = 3;
  localparam int RW = 2;        // index width of the coefficient file
  localparam int NUM_W = 49;    // shifted dividend magnitude
  localparam int DEN_W = 33;    // divisor magnitude

  // Datapath operations.
  typedef logic [3:0] op_t;
  localparam op_t OP_NOP    = 4'd0;
  localparam op_t OP_BEST   = 4'd1;
  localparam op_t OP_CMP    = 4'd2;
  localparam op_t OP_FILL   = 4'd3;
  localparam op_t OP_RFRD   = 4'd4;
  localparam op_t OP_DIVGO  = 4'd5;
  localparam op_t OP_DIVWR  = 4'd6;
  localparam op_t OP_PINIT  = 4'd7;
  localparam op_t OP_MUL    = 4'd8;
  localparam op_t OP_ACC    = 4'd9;

  typedef struct packed {
    op_t           op;
    logic [RW-1:0] ia;
    logic [RW-1:0] ib;
    logic          mem_we;
    logic          mem_re;
    logic          q_load;
    logic          res_load;
    logic [1:0]    res_status;
  } cmd_t;

  typedef struct packed {
    logic den_zero;
    logic d_lt;
    logic div_busy;
  } stat_t;

endpackage

>>> rtl/newton_table_interpolator_unit.sv
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  in_item  (opcode, x_value, fx_value)
// out      output     out_valid/out_stall  out_item (interp_value, status)
// cfg      input      cfg_wen              cfg_wdata (interp_order)
//
// A load is taken at once. A query walks the nearest search, the table fetch, the divided
// differences and the nested evaluation; the 49-step restoring divider dominates.
// Too-few and bad-order results go straight to the result state and wait there for the slot.
// Reset is synchronous; the table holds no data until loaded.
// Items are taken one at a time; an input is accepted while a result still
// waits behind out_stall, and a query result waits there for the slot.
module newton_table_interpolator_unit #(
  parameter int MAX_POINTS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wen,
  input  logic [2:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  nti_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output nti_pkg::out_item_t out_item
);

  nti_pkg::cmd_t                 cmd;
  nti_pkg::stat_t                stat;
  logic [$clog2(MAX_POINTS)-1:0] addr;

  nti_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_opcode (in_item.opcode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd),
    .addr      (addr)
  );

  nti_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .addr     (addr),
    .in_item  (in_item),
    .stat     (stat),
    .out_item (out_item)
  );

endmodule

>>> rtl/nti_divider.sv
// Restoring divider, one quotient bit per cycle, unsigned magnitudes.
module nti_divider (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [nti_pkg::NUM_W-1:0] num,
  input  logic [nti_pkg::DEN_W-1:0] den,
  output logic                      busy,
  output logic [nti_pkg::NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(nti_pkg::NUM_W + 1);

  logic [nti_pkg::DEN_W-1:0] rem;
  logic [nti_pkg::DEN_W-1:0] dv;
  logic [CNT_W-1:0]          cnt;
  logic [nti_pkg::DEN_W:0]   rem_sh;
  logic                      fits;

  // Trial subtraction of the shifted remainder.
  assign rem_sh = {rem, quo[nti_pkg::NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(nti_pkg::NUM_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Dividend shifts out at the top while quotient bits enter below.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dv  <= den;
      quo <= num;
    end else if (busy) begin
      rem <= fits ? nti_pkg::DEN_W'(rem_sh - {1'b0, dv}) : rem_sh[nti_pkg::DEN_W-1:0];
      quo <= {quo[nti_pkg::NUM_W-2:0], fits};
    end
  end

endmodule

>>> rtl/nti_datapath.sv
// Point table, coefficient file, divider and multiply-accumulate path.
module nti_datapath #(
  parameter int MAX_POINTS = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  nti_pkg::cmd_t                 cmd,
  input  logic [$clog2(MAX_POINTS)-1:0] addr,
  input  nti_pkg::in_item_t             in_item,
  output nti_pkg::stat_t                stat,
  output nti_pkg::out_item_t            out_item
);

  localparam int NR = nti_pkg::MAX_ORDER + 1;

  logic signed [31:0] x_mem  [MAX_POINTS];
  logic signed [31:0] fx_mem [MAX_POINTS];
  logic signed [31:0] rd_x, rd_fx;
  logic signed [31:0] q;
  logic [32:0]        best;

  logic signed [31:0] xs_rf [NR];
  logic signed [31:0] c_rf  [NR];
  logic signed [31:0] opa_x, opa_c, opb_x, opb_c;

  logic signed [32:0] xdiff, den, num, dq;
  logic [32:0]        gap, den_mag, num_mag, dq_mag;
  logic [31:0]        p_mag;
  logic               div_neg, div_start, mul_neg;
  logic [nti_pkg::NUM_W-1:0] quo;
  logic signed [31:0] quo_sat;
  logic [64:0]        prod;
  logic [48:0]        m;
  logic signed [50:0] term, sum;
  logic signed [31:0] p, p_next;

  // Table memory: one port, write on load, registered read.
  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      x_mem[addr]  <= in_item.x_value;
      fx_mem[addr] <= in_item.fx_value;
    end
    if (cmd.mem_re) begin
      rd_x  <= x_mem[addr];
      rd_fx <= fx_mem[addr];
    end
  end

  // Distance of the fetched abscissa to the query.
  assign xdiff = 33'(rd_x) - 33'(q);
  assign gap   = xdiff[32] ? 33'(-xdiff) : 33'(xdiff);

  always_ff @(posedge clk) begin
    if (cmd.q_load) begin
      q <= in_item.x_value;
    end
    if (cmd.op == nti_pkg::OP_BEST || (cmd.op == nti_pkg::OP_CMP && stat.d_lt)) begin
      best <= gap;
    end
  end

  // Divided-difference operands.
  assign den     = 33'(opa_x) - 33'(opb_x);
  assign num     = 33'(opa_c) - 33'(opb_c);
  assign den_mag = den[32] ? 33'(-den) : 33'(den);
  assign num_mag = num[32] ? 33'(-num) : 33'(num);
  assign div_start = (cmd.op == nti_pkg::OP_DIVGO) && (den != '0);

  nti_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({num_mag, 16'h0000}),
    .den   (den_mag),
    .busy  (stat.div_busy),
    .quo   (quo)
  );

  // Saturate the quotient to Q16.16.
  always_comb begin
    if (div_neg) begin
      quo_sat = (quo > 49'd2147483648) ? 32'sh80000000 : 32'(-quo[31:0]);
    end else begin
      quo_sat = (quo > 49'd2147483647) ? 32'sh7fffffff : quo[31:0];
    end
  end

  assign stat.den_zero = (den == '0);
  assign stat.d_lt     = gap < best;

  // Coefficient file: one write address, registered reads. The numerator
  // always takes the coefficient just below the one being replaced.
  always_ff @(posedge clk) begin
    if (cmd.op == nti_pkg::OP_FILL) begin
      xs_rf[cmd.ia] <= rd_x;
      c_rf[cmd.ia]  <= rd_fx;
    end else if (cmd.op == nti_pkg::OP_DIVWR) begin
      c_rf[cmd.ia] <= quo_sat;
    end
    if (cmd.op == nti_pkg::OP_RFRD) begin
      opa_x <= xs_rf[cmd.ia];
      opa_c <= c_rf[cmd.ia];
      opb_x <= xs_rf[cmd.ib];
      opb_c <= c_rf[cmd.ia - 1'b1];
    end
    if (cmd.op == nti_pkg::OP_DIVGO) begin
      div_neg <= num[32] ^ den[32];
    end
  end

  // Nested evaluation: product, then add and saturate.
  assign dq     = 33'(q) - 33'(opb_x);
  assign dq_mag = dq[32] ? 33'(-dq) : 33'(dq);
  assign p_mag  = p[31] ? 32'(-p) : 32'(p);
  assign m      = prod[64:16];
  assign term   = mul_neg ? -$signed({2'b00, m}) : $signed({2'b00, m});
  assign sum    = 51'(opa_c) + term;

  always_comb begin
    p_next = p;
    unique case (cmd.op)
      nti_pkg::OP_PINIT: p_next = opa_c;
      nti_pkg::OP_ACC: begin
        if (sum[50:31] != {20{sum[50]}}) begin
          p_next = sum[50] ? 32'sh80000000 : 32'sh7fffffff;
        end else begin
          p_next = sum[31:0];
        end
      end
      default: p_next = p;
    endcase
  end

  always_ff @(posedge clk) begin
    p <= p_next;
    if (cmd.op == nti_pkg::OP_MUL) begin
      prod    <= 65'(p_mag) * 65'(dq_mag);
      mul_neg <= p[31] ^ dq[32];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_item.interp_value <= (cmd.res_status == nti_pkg::ST_OK) ? p : 32'sd0;
      out_item.status       <= cmd.res_status;
    end
  end

endmodule

>>> rtl/nti_ctrl.sv
`include "newton_table_interpolator_unit_defines.svh"

// Sequencer: table loads, nearest search, divided differences, evaluation.
module nti_ctrl #(
  parameter int MAX_POINTS = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wen,
  input  logic [2:0]                    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_opcode,
  output logic                          out_valid,
  input  logic                          out_stall,
  input  nti_pkg::stat_t                stat,
  output nti_pkg::cmd_t                 cmd,
  output logic [$clog2(MAX_POINTS)-1:0] addr
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_BEST  = 4'd1;
  localparam logic [3:0] S_SCAN  = 4'd2;
  localparam logic [3:0] S_FREAD = 4'd3;
  localparam logic [3:0] S_FWR   = 4'd4;
  localparam logic [3:0] S_DRD   = 4'd5;
  localparam logic [3:0] S_DGO   = 4'd6;
  localparam logic [3:0] S_DWAIT = 4'd7;
  localparam logic [3:0] S_PRD   = 4'd8;
  localparam logic [3:0] S_PINIT = 4'd9;
  localparam logic [3:0] S_ERD   = 4'd10;
  localparam logic [3:0] S_MUL   = 4'd11;
  localparam logic [3:0] S_ACC   = 4'd12;
  localparam logic [3:0] S_RES   = 4'd13;

  logic [3:0]           state, state_next;
  logic [2:0]           order;
  logic [CW-1:0]        count, count_next;
  logic [AW-1:0]        near, near_next;
  logic [nti_pkg::RW-1:0] idx, idx_next, lev, lev_next, ord2;
  logic [1:0]           res_status, res_status_next;
  logic                 in_fire, out_fire;
  logic [CW-1:0]        upper_w;
  logic [AW-1:0]        upper, kmin;

  assign in_stall = (state != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;
  assign ord2     = order[nti_pkg::RW-1:0];

  // Last index at which a full set of points still fits.
  assign upper_w = count - CW'(order) - CW'(1);
  assign upper   = upper_w[AW-1:0];
  assign kmin    = (near > upper) ? upper : near;

  always_comb begin
    state_next      = state;
    count_next      = count;
    near_next       = near;
    idx_next        = idx;
    lev_next        = lev;
    res_status_next = res_status;
    cmd             = '0;
    cmd.op          = nti_pkg::OP_NOP;
    cmd.res_status  = res_status;
    addr            = near;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.q_load = 1'b1;
          if (in_opcode == nti_pkg::OPC_LOAD) begin
            if (count < CW'(MAX_POINTS)) begin
              cmd.mem_we = 1'b1;
              addr       = count[AW-1:0];
              count_next = count + 1'b1;
              near_next  = '0;
            end
          end else if (count == '0 || count < CW'(order) + CW'(1)) begin
            res_status_next = nti_pkg::ST_TOO_FEW;
            state_next      = S_RES;
          end else if (order > 3'(nti_pkg::MAX_ORDER)) begin
            res_status_next = nti_pkg::ST_BAD_ORDER;
            state_next      = S_RES;
          end else begin
            near_next  = kmin;
            addr       = kmin;
            cmd.mem_re = 1'b1;
            state_next = S_BEST;
          end
        end
      end
      S_BEST: begin
        cmd.op   = nti_pkg::OP_BEST;
        idx_next = '0;
        if (near < upper) begin
          addr       = near + 1'b1;
          cmd.mem_re = 1'b1;
          state_next = S_SCAN;
        end else begin
          state_next = S_FREAD;
        end
      end
      // Walk forward while the distance keeps shrinking.
      S_SCAN: begin
        cmd.op   = nti_pkg::OP_CMP;
        idx_next = '0;
        if (stat.d_lt) begin
          near_next = near + 1'b1;
          if (near + 1'b1 < upper) begin
            addr       = near + AW'(2);
            cmd.mem_re = 1'b1;
          end else begin
            state_next = S_FREAD;
          end
        end else begin
          state_next = S_FREAD;
        end
      end
      S_FREAD: begin
        addr       = near + AW'(idx);
        cmd.mem_re = 1'b1;
        state_next = S_FWR;
      end
      S_FWR: begin
        cmd.op = nti_pkg::OP_FILL;
        cmd.ia = idx;
        if (idx == ord2) begin
          if (ord2 == '0) begin
            state_next = S_PRD;
          end else begin
            lev_next   = nti_pkg::RW'(1);
            idx_next   = ord2;
            state_next = S_DRD;
          end
        end else begin
          idx_next   = idx + 1'b1;
          state_next = S_FREAD;
        end
      end
      S_DRD: begin
        cmd.op     = nti_pkg::OP_RFRD;
        cmd.ia     = idx;
        cmd.ib     = idx - lev;
        state_next = S_DGO;
      end
      S_DGO: begin
        cmd.op = nti_pkg::OP_DIVGO;
        if (stat.den_zero) begin
          res_status_next = nti_pkg::ST_DIV_ZERO;
          state_next      = S_RES;
        end else begin
          state_next = S_DWAIT;
        end
      end
      // Once the divider is done, write the quotient and step to the next difference or to evaluation.
      S_DWAIT: begin
        if (!stat.div_busy) begin
          cmd.op = nti_pkg::OP_DIVWR;
          cmd.ia = idx;
          if (idx > lev) begin
            idx_next   = idx - 1'b1;
            state_next = S_DRD;
          end else if (lev < ord2) begin
            lev_next   = lev + 1'b1;
            idx_next   = ord2;
            state_next = S_DRD;
          end else begin
            state_next = S_PRD;
          end
        end
      end
      S_PRD: begin
        cmd.op     = nti_pkg::OP_RFRD;
        cmd.ia     = ord2;
        cmd.ib     = ord2;
        state_next = S_PINIT;
      end
      S_PINIT: begin
        cmd.op          = nti_pkg::OP_PINIT;
        idx_next        = ord2;
        res_status_next = nti_pkg::ST_OK;
        state_next      = (ord2 == '0) ? S_RES : S_ERD;
      end
      S_ERD: begin
        cmd.op     = nti_pkg::OP_RFRD;
        cmd.ia     = idx - 1'b1;
        cmd.ib     = idx - 1'b1;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.op     = nti_pkg::OP_MUL;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.op     = nti_pkg::OP_ACC;
        idx_next   = idx - 1'b1;
        state_next = (idx == nti_pkg::RW'(1)) ? S_RES : S_ERD;
      end
      S_RES: begin
        if (!out_valid || !out_stall) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      order      <= 3'd1;
      count      <= '0;
      near       <= '0;
      idx        <= '0;
      lev        <= '0;
      res_status <= nti_pkg::ST_OK;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      near       <= near_next;
      idx        <= idx_next;
      lev        <= lev_next;
      res_status <= res_status_next;
      if (cfg_wen) begin
        order <= cfg_wdata;
      end
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
    end
  end

  // A result is only written into a free or draining output slot.
  `NTI_ASSERT_ALWAYS(a_res_slot, !cmd.res_load || !out_valid || !out_stall)
  // The fill count never passes the table size.
  `NTI_ASSERT_ALWAYS(a_count_max, count <= CW'(MAX_POINTS))
  // A load into a non-full table grows the count by one.
  `NTI_ASSERT_NEXT(a_load_count, in_fire && in_opcode == nti_pkg::OPC_LOAD &&
    count < CW'(MAX_POINTS), count == $past(count) + 1'b1)
  // The sequencer holds while the divider is running.
  `NTI_ASSERT_NEXT(a_div_hold, state == S_DWAIT && stat.div_busy, state == S_DWAIT)

endmodule

>>> bench/tb_newton_table_interpolator_unit.sv
module tb_newton_table_interpolator_unit;

  localparam int TABLE_DEPTH = 256;
  localparam int SETTLE_CYCLES = 800;
  localparam int CYCLE_LIMIT = 4000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wen = 1'b0;
  logic [2:0] cfg_wdata = 3'd0;
  logic in_valid = 1'b0;
  logic in_stall;
  nti_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  nti_pkg::out_item_t out_item;

  newton_table_interpolator_unit #(.MAX_POINTS(TABLE_DEPTH)) DUT (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow of the block's table, counters and order register.
  longint pt_x[TABLE_DEPTH];
  longint pt_fx[TABLE_DEPTH];
  int pt_count = 0;
  int nearest = 0;
  int order_reg = 1;

  nti_pkg::out_item_t pending_results[$];
  int mismatches = 0;
  int cycles = 0;
  bit calm = 1'b0;

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint sat_q(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Fixed-point quotient, truncated toward zero and saturated.
  function automatic longint fx_div(longint num, longint den);
    longint unsigned q;
    q = (magnitude(num) << 16) / magnitude(den);
    if ((num < 0) != (den < 0)) return q > 64'd2147483648 ? -64'sd2147483648 : -longint'(q);
    return q > 64'd2147483647 ? 64'sd2147483647 : longint'(q);
  endfunction

  function automatic longint fx_mul(longint a, longint d);
    longint unsigned m;
    m = (magnitude(a) * magnitude(d)) >> 16;
    return ((a < 0) != (d < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint abs_gap(longint a, longint b);
    return a > b ? a - b : b - a;
  endfunction

  // Applies one item to the shadow state and gives the result of a query.
  function automatic bit interpolate(input nti_pkg::in_item_t it,
                                     output nti_pkg::out_item_t res);
    longint qx, best, d, den, acc;
    longint xs[4];
    longint c[4];
    int k, upper;
    res = '0;
    qx = longint'(it.x_value);
    if (it.opcode == nti_pkg::OPC_LOAD) begin
      if (pt_count < TABLE_DEPTH) begin
        pt_x[pt_count] = qx;
        pt_fx[pt_count] = longint'(it.fx_value);
        pt_count++;
        nearest = 0;
      end
      return 1'b0;
    end
    if (pt_count == 0 || pt_count < order_reg + 1) begin
      res.status = nti_pkg::ST_TOO_FEW;
      return 1'b1;
    end
    if (order_reg > nti_pkg::MAX_ORDER) begin
      res.status = nti_pkg::ST_BAD_ORDER;
      return 1'b1;
    end
    // Forward search for the nearest abscissa.
    upper = pt_count - order_reg - 1;
    k = nearest > upper ? upper : nearest;
    best = abs_gap(pt_x[k], qx);
    for (int j = k + 1; j <= upper; j++) begin
      d = abs_gap(pt_x[j], qx);
      if (d < best) begin
        best = d;
        k = j;
      end else begin
        break;
      end
    end
    nearest = k;
    for (int i = 0; i <= order_reg; i++) begin
      xs[i] = pt_x[k + i];
      c[i] = pt_fx[k + i];
    end
    // Divided differences in place, level by level.
    for (int lev = 1; lev <= order_reg; lev++) begin
      for (int i = order_reg; i >= lev; i--) begin
        den = xs[i] - xs[i - lev];
        if (den == 0) begin
          res.status = nti_pkg::ST_DIV_ZERO;
          return 1'b1;
        end
        c[i] = fx_div(c[i] - c[i - 1], den);
      end
    end
    // Nested evaluation of the polynomial.
    acc = c[order_reg];
    for (int i = order_reg; i > 0; i--) acc = sat_q(c[i - 1] + fx_mul(acc, qx - xs[i - 1]));
    res.interp_value = acc[31:0];
    res.status = nti_pkg::ST_OK;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    mismatches++;
  endtask

  // Offers one item, holds it until accepted and records what it should give.
  task automatic send_item(input nti_pkg::in_item_t it, input bit typed,
                           input nti_pkg::out_item_t typed_res);
    nti_pkg::out_item_t res;
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 33) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_item = it;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    if (interpolate(it, res)) pending_results.push_back(typed ? typed_res : res);
  endtask

  // Waits for every result and for a trailing load, then writes the order.
  task automatic set_order(input int ord);
    @(negedge clk);
    in_valid = 1'b0;
    wait (pending_results.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_wen = 1'b1;
    cfg_wdata = 3'(ord);
    @(negedge clk);
    cfg_wen = 1'b0;
    order_reg = ord;
  endtask

  // Receiver side: random stall, check each accepted result.
  always @(negedge clk) out_stall = !calm && $urandom_range(0, 99) < 33;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout");
      $display("[FAIL] regression broken");
      $finish;
    end
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with none expected");
      end else begin
        if (out_item.interp_value !== pending_results[0].interp_value)
          report_mismatch($sformatf("interp_value %h expected %h", out_item.interp_value,
                                    pending_results[0].interp_value));
        if (out_item.status !== pending_results[0].status)
          report_mismatch($sformatf("status %0d expected %0d", out_item.status,
                                    pending_results[0].status));
        void'(pending_results.pop_front());
      end
    end
  end

  typedef struct {
    int ord;
    logic opc;
    logic [31:0] xv;
    logic [31:0] fxv;
    bit typed;
    logic [1:0] st;
  } step_row_t;

  step_row_t rows[$];
  int order_choice[7] = '{0, 1, 2, 3, 7, 4, 3};
  int ord_now;
  nti_pkg::in_item_t it;
  nti_pkg::out_item_t ex;
  longint cursor, qx;
  int idx;

  initial begin
    // Directed steps: empty table, each order, saturating points, equal abscissas.
    rows.push_back('{1, nti_pkg::OPC_QUERY, 32'h0, 32'h0, 1, nti_pkg::ST_TOO_FEW});
    rows.push_back('{1, nti_pkg::OPC_LOAD, 32'h8000_0000, 32'h7fff_ffff, 0, nti_pkg::ST_OK});
    rows.push_back('{1, nti_pkg::OPC_QUERY, 32'h0, 32'h0, 1, nti_pkg::ST_TOO_FEW});
    rows.push_back('{0, nti_pkg::OPC_QUERY, 32'h7fff_ffff, 32'hffff_ffff, 0, nti_pkg::ST_OK});
    rows.push_back('{4, nti_pkg::OPC_QUERY, 32'h0, 32'h0, 1, nti_pkg::ST_TOO_FEW});
    rows.push_back('{7, nti_pkg::OPC_QUERY, 32'h0, 32'h0, 1, nti_pkg::ST_TOO_FEW});
    rows.push_back('{1, nti_pkg::OPC_LOAD, 32'h0001_0000, 32'h8000_0000, 0, nti_pkg::ST_OK});
    rows.push_back('{1, nti_pkg::OPC_QUERY, 32'h8000_0000, 32'h0, 0, nti_pkg::ST_OK});
    rows.push_back('{1, nti_pkg::OPC_QUERY, 32'h7fff_ffff, 32'h0, 0, nti_pkg::ST_OK});
    rows.push_back('{1, nti_pkg::OPC_LOAD, 32'h0001_0000, 32'h0000_0000, 0, nti_pkg::ST_OK});
    rows.push_back('{1, nti_pkg::OPC_QUERY, 32'h0001_0000, 32'h0, 0, nti_pkg::ST_OK});
    rows.push_back('{1, nti_pkg::OPC_LOAD, 32'h0003_0000, 32'h0002_0000, 0, nti_pkg::ST_OK});
    rows.push_back('{1, nti_pkg::OPC_LOAD, 32'h7fff_ffff, 32'h7fff_ffff, 0, nti_pkg::ST_OK});
    rows.push_back('{3, nti_pkg::OPC_QUERY, 32'h0002_0000, 32'h0, 0, nti_pkg::ST_OK});
    rows.push_back('{3, nti_pkg::OPC_QUERY, 32'h7fff_0000, 32'h0, 0, nti_pkg::ST_OK});
    rows.push_back('{2, nti_pkg::OPC_QUERY, 32'h0003_0000, 32'h0, 0, nti_pkg::ST_OK});
    rows.push_back('{2, nti_pkg::OPC_QUERY, 32'h8000_0000, 32'h0, 0, nti_pkg::ST_OK});
    rows.push_back('{2, nti_pkg::OPC_QUERY, 32'h7fff_ffff, 32'h0, 0, nti_pkg::ST_OK});

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    ord_now = 1;
    foreach (rows[r]) begin
      if (rows[r].ord != ord_now) begin
        set_order(rows[r].ord);
        ord_now = rows[r].ord;
      end
      it.opcode = rows[r].opc;
      it.x_value = rows[r].xv;
      it.fx_value = rows[r].fxv;
      ex.interp_value = '0;
      ex.status = rows[r].st;
      send_item(it, rows[r].typed, ex);
    end

    // Random phases: mostly sorted loads and queries that walk forward.
    cursor = -64'sd33554432 + $urandom_range(0, 65535);
    for (int ph = 0; ph < 8; ph++) begin
      set_order(ph == 7 ? $urandom_range(0, 7) : order_choice[ph]);
      calm = (ph == 2);
      for (int n = 0; n < 104; n++) begin
        if ($urandom_range(0, 99) < 8) begin
          // Noise: fully random item.
          it.opcode = 1'($urandom);
          it.x_value = $urandom;
          it.fx_value = $urandom;
        end else if (pt_count < TABLE_DEPTH && $urandom_range(0, 99) < 45) begin
          it.opcode = nti_pkg::OPC_LOAD;
          if ($urandom_range(0, 99) >= 6) cursor += $urandom_range(1, 32'h40000);
          it.x_value = 32'(cursor);
          it.fx_value = $urandom_range(0, 99) < 10 ? $urandom
                                                   : 32'($signed($urandom_range(0, 32'h7ffff)) - 32'sh40000);
        end else begin
          it.opcode = nti_pkg::OPC_QUERY;
          it.fx_value = $urandom;
          if (pt_count == 0) begin
            qx = cursor;
          end else begin
            idx = nearest + $urandom_range(0, 3);
            if (idx >= pt_count) idx = pt_count - 1;
            qx = pt_x[idx] + $signed($urandom_range(0, 32'h40000)) - 32'sh20000;
          end
          it.x_value = 32'(sat_q(qx));
        end
        send_item(it, 1'b0, ex);
      end
      calm = 1'b0;
    end

    @(negedge clk);
    in_valid = 1'b0;
    wait (pending_results.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/nti_pkg.sv
rtl/nti_divider.sv
rtl/nti_datapath.sv
rtl/nti_ctrl.sv
rtl/newton_table_interpolator_unit.sv
bench/tb_newton_table_interpolator_unit.sv
